// ===== rtl/core/gbr_pkg.sv =====
package gbr_pkg;

	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;
	localparam int CFG_W  = 12;
	localparam int CFG_IDX_W = 2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CFG_W-1:0] cfg_word_t;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW      = 2'd3;

	localparam cfg_word_t RST_IMAGE_WIDTH  = 12'd640;
	localparam cfg_word_t RST_IMAGE_HEIGHT = 12'd480;
	localparam cfg_word_t RST_FIRST_ROW    = 12'd0;
	localparam cfg_word_t RST_END_ROW      = 12'd2048;

	localparam int MIN_DIM = 3;

	// 1-2-1 kernel: weights sum to 16
	localparam int BLUR_SHIFT = 4;
	localparam int SUM_W = CHAN_W + BLUR_SHIFT;

	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	// One line-buffer entry: the pixel of the row above and of the current row
	typedef struct packed {
		pix_t above;
		pix_t cur;
	} line_entry_t;

	typedef struct packed {
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] c;
		logic              last;
	} out_item_t;

endpackage

// ===== rtl/core/gaussian_blur_3x3_rgb_core.sv =====
// 3x3 binomial blur (1-2-1 / 2-4-2 / 1-2-1, divided by 16, truncated) over a raster-order
// stream of 24-bit pixels, each byte filtered on its own. One item is taken every clock
// while in_stall is low; the line memory has one read and one write port and each pixel does
// one read-modify-write of its column entry, which sets the rate. Items pass stage 1 and stage 2
// into the output queue; output trails input by one row plus one pixel, so after the last pixel
// of a frame send width+1 drain items (mode 1) to flush the rest, the final one flagged frame_last.
// Border pixels and rows outside [first_row, end_row) pass through. Frame width and height
// are sampled at the first pixel of each frame and clamped to 3..MAX_WIDTH / 3..MAX_HEIGHT.
// in_stall rises when the 4-entry output queue plus the two items in flight would fill it.
// Write registers only while the block is idle; cfg_ready is always high. No clearing
// pass is needed after reset.
module gaussian_blur_3x3_rgb_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [gbr_pkg::CHAN_W-1:0]        chan_a,
	input  logic [gbr_pkg::CHAN_W-1:0]        chan_b,
	input  logic [gbr_pkg::CHAN_W-1:0]        chan_c,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [gbr_pkg::CHAN_W-1:0]        out_a,
	output logic [gbr_pkg::CHAN_W-1:0]        out_b,
	output logic [gbr_pkg::CHAN_W-1:0]        out_c,
	output logic                              frame_last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbr_pkg::CFG_W-1:0]         cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

	// Configuration registers
	gbr_pkg::cfg_word_t image_width_q, image_height_q, first_row_q, end_row_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= gbr_pkg::RST_IMAGE_WIDTH;
			image_height_q <= gbr_pkg::RST_IMAGE_HEIGHT;
			first_row_q    <= gbr_pkg::RST_FIRST_ROW;
			end_row_q      <= gbr_pkg::RST_END_ROW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gbr_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				gbr_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				gbr_pkg::REG_FIRST_ROW:    first_row_q    <= cfg_data;
				gbr_pkg::REG_END_ROW:      end_row_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame geometry and input position
	logic [WD_W-1:0]  frame_w_q;
	logic [HT_W-1:0]  frame_h_q;
	logic [COL_W-1:0] in_col_q;
	logic [HT_W-1:0]  in_row_q;
	logic [WD_W-1:0]  drain_idx_q;

	logic [WD_W-1:0] clamp_w;
	logic [HT_W-1:0] clamp_h;

	always_comb begin
		if (32'(image_width_q) < gbr_pkg::MIN_DIM) begin
			clamp_w = WD_W'(gbr_pkg::MIN_DIM);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			clamp_w = WD_W'(MAX_WIDTH);
		end else begin
			clamp_w = WD_W'(image_width_q);
		end
		if (32'(image_height_q) < gbr_pkg::MIN_DIM) begin
			clamp_h = HT_W'(gbr_pkg::MIN_DIM);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			clamp_h = HT_W'(MAX_HEIGHT);
		end else begin
			clamp_h = HT_W'(image_height_q);
		end
	end

	logic                         accept;
	logic                         frame_start;
	logic [WD_W-1:0]              fw_eff;
	logic [HT_W-1:0]              fh_eff;
	logic                         pix_take;
	logic                         drain_take;
	logic                         pix_emit;
	logic                         pix_interior;
	logic                         drain_last;
	logic                         col_wrap;
	logic [COL_W-1:0]             rd_addr;
	logic [gbr_pkg::OFIFO_CNT_W-1:0] fifo_count;
	logic [gbr_pkg::OFIFO_CNT_W:0]   committed;

	logic                         valid_s1, pix_s1, emit_s1, interior_s1, last_s1, sel_cur_s1;
	logic [COL_W-1:0]             addr_s1;
	gbr_pkg::pix_t                px_s1;
	logic                         emit_s2, interior_s2, drain_s2, last_s2;
	gbr_pkg::pix_t                drain_px_s2;

	assign committed = (gbr_pkg::OFIFO_CNT_W+1)'(fifo_count)
		+ (gbr_pkg::OFIFO_CNT_W+1)'(emit_s1) + (gbr_pkg::OFIFO_CNT_W+1)'(emit_s2);
	assign in_stall  = 32'(committed) >= gbr_pkg::OFIFO_DEPTH;
	assign accept    = in_valid && !in_stall;

	assign frame_start = (in_row_q == '0) && (in_col_q == '0);
	assign fw_eff      = frame_start ? clamp_w : frame_w_q;
	assign fh_eff      = frame_start ? clamp_h : frame_h_q;
	assign pix_take    = accept && !mode && (in_row_q < fh_eff);
	assign drain_take  = accept && mode && (in_row_q >= frame_h_q);
	assign col_wrap    = 32'(in_col_q) + 32'd1 >= 32'(fw_eff);
	assign drain_last  = drain_idx_q == frame_w_q;

	// Output position trails by one row plus one pixel
	assign pix_emit = (32'(in_row_q) >= 32'd2) || ((in_row_q == HT_W'(1)) && (in_col_q != '0));
	assign pix_interior = (32'(in_row_q) >= 32'd2) && (32'(in_col_q) >= 32'd2)
		&& (32'(in_row_q) >= 32'(first_row_q) + 32'd1)
		&& (32'(in_row_q) < 32'(end_row_q) + 32'd1);

	// First drain item reads the last column of the row above, the rest the current row
	always_comb begin
		if (!mode) begin
			rd_addr = in_col_q;
		end else if (drain_idx_q == '0) begin
			rd_addr = COL_W'(frame_w_q - WD_W'(1));
		end else begin
			rd_addr = COL_W'(drain_idx_q - WD_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q   <= WD_W'(MAX_WIDTH);
			frame_h_q   <= HT_W'(MAX_HEIGHT);
			in_col_q    <= '0;
			in_row_q    <= '0;
			drain_idx_q <= '0;
		end else begin
			if (accept && !mode && frame_start) begin
				frame_w_q <= clamp_w;
				frame_h_q <= clamp_h;
			end
			if (pix_take) begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HT_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (drain_take) begin
				if (drain_last) begin
					in_col_q    <= '0;
					in_row_q    <= '0;
					drain_idx_q <= '0;
				end else begin
					drain_idx_q <= drain_idx_q + WD_W'(1);
				end
			end
		end
	end

	// Stage 1: line entry arrives, window shifts, entry written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pix_s1      <= 1'b0;
			emit_s1     <= 1'b0;
			interior_s1 <= 1'b0;
			last_s1     <= 1'b0;
			sel_cur_s1  <= 1'b0;
		end else begin
			valid_s1    <= pix_take || drain_take;
			pix_s1      <= pix_take;
			emit_s1     <= (pix_take && pix_emit) || drain_take;
			interior_s1 <= pix_take && pix_interior;
			last_s1     <= drain_take && drain_last;
			sel_cur_s1  <= drain_idx_q != '0;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		px_s1   <= {chan_c, chan_b, chan_a};
	end

	logic [$bits(gbr_pkg::line_entry_t)-1:0] rd_raw;
	gbr_pkg::line_entry_t                    rd_entry;
	gbr_pkg::line_entry_t                    wr_entry;

	assign rd_entry       = gbr_pkg::line_entry_t'(rd_raw);
	assign wr_entry.above = rd_entry.cur;
	assign wr_entry.cur   = px_s1;

	gbr_line_mem #(
		.DEPTH (MAX_WIDTH),
		.DW    ($bits(gbr_pkg::line_entry_t))
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pix_take || drain_take),
		.rd_addr (rd_addr),
		.rd_data (rd_raw),
		.wr_en   (valid_s1 && pix_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_entry)
	);

	gbr_pkg::pix_t win_center, win_blur;

	gbr_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (valid_s1 && pix_s1),
		.above  (rd_entry.above),
		.cur    (rd_entry.cur),
		.px     (px_s1),
		.center (win_center),
		.blur   (win_blur)
	);

	// Stage 2: pick filtered, passed-through or drained pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2     <= 1'b0;
			interior_s2 <= 1'b0;
			drain_s2    <= 1'b0;
			last_s2     <= 1'b0;
		end else begin
			emit_s2     <= emit_s1;
			interior_s2 <= interior_s1;
			drain_s2    <= valid_s1 && !pix_s1;
			last_s2     <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		drain_px_s2 <= sel_cur_s1 ? rd_entry.cur : rd_entry.above;
	end

	gbr_pkg::pix_t      res_px;
	gbr_pkg::out_item_t push_item, head;
	logic               pop;

	assign res_px = drain_s2 ? drain_px_s2 : (interior_s2 ? win_blur : win_center);
	assign push_item.a    = res_px[0 +: gbr_pkg::CHAN_W];
	assign push_item.b    = res_px[gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W];
	assign push_item.c    = res_px[2*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W];
	assign push_item.last = last_s2;

	assign out_valid = fifo_count != '0;
	assign pop       = out_valid && !out_stall;

	gbr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s2),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.count     (fifo_count)
	);

	assign out_a      = head.a;
	assign out_b      = head.b;
	assign out_c      = head.c;
	assign frame_last = head.last;

	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_s2 && !pop && (32'(fifo_count) == gbr_pkg::OFIFO_DEPTH)))
		else $error("output queue overflow");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= frame_h_q)
		else $error("input row past frame height");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_idx_q != '0) |-> ((drain_idx_q <= frame_w_q) && (in_row_q == frame_h_q)))
		else $error("drain index out of range");

	a_last_is_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |=> (emit_s2 && drain_s2))
		else $error("frame_last on a non-drain item");

endmodule

// ===== rtl/core/gbr_line_mem.sv =====
module gbr_line_mem #(
	parameter int DEPTH = 2048,
	parameter int DW    = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_q;
	logic          fwd_hit_q;
	logic [DW-1:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// A read that meets a write to the same entry returns the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= rd_en && wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/core/gbr_window.sv =====
module gbr_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  gbr_pkg::pix_t above,
	input  gbr_pkg::pix_t cur,
	input  gbr_pkg::pix_t px,
	output gbr_pkg::pix_t center,
	output gbr_pkg::pix_t blur
);

	gbr_pkg::pix_t win_q [9];

	// index row*3+col, col 0 oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= above;
			win_q[5] <= cur;
			win_q[8] <= px;
		end
	end

	assign center = win_q[4];

	always_comb begin
		logic [gbr_pkg::SUM_W-1:0] corners;
		logic [gbr_pkg::SUM_W-1:0] edges;
		logic [gbr_pkg::SUM_W-1:0] sum;
		blur = '0;
		for (int ch = 0; ch < 3; ch++) begin
			corners = gbr_pkg::SUM_W'(win_q[0][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W])
				+ gbr_pkg::SUM_W'(win_q[2][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W])
				+ gbr_pkg::SUM_W'(win_q[6][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W])
				+ gbr_pkg::SUM_W'(win_q[8][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W]);
			edges = gbr_pkg::SUM_W'(win_q[1][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W])
				+ gbr_pkg::SUM_W'(win_q[3][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W])
				+ gbr_pkg::SUM_W'(win_q[5][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W])
				+ gbr_pkg::SUM_W'(win_q[7][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W]);
			sum = corners + (edges << 1)
				+ (gbr_pkg::SUM_W'(win_q[4][ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W]) << 2);
			blur[ch*gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W] =
				sum[gbr_pkg::BLUR_SHIFT +: gbr_pkg::CHAN_W];
		end
	end

endmodule

// ===== rtl/core/gbr_out_fifo.sv =====
module gbr_out_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  gbr_pkg::out_item_t                 push_item,
	input  logic                               pop,
	output gbr_pkg::out_item_t                 head,
	output logic [gbr_pkg::OFIFO_CNT_W-1:0]    count
);

	localparam int PTR_W = $clog2(gbr_pkg::OFIFO_DEPTH);

	gbr_pkg::out_item_t           buf_q [gbr_pkg::OFIFO_DEPTH];
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [PTR_W-1:0]             rd_ptr_q;
	logic [gbr_pkg::OFIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == gbr_pkg::OFIFO_DEPTH - 1) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == gbr_pkg::OFIFO_DEPTH - 1) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + gbr_pkg::OFIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - gbr_pkg::OFIFO_CNT_W'(1);
			end
		end
	end

	assign head  = buf_q[rd_ptr_q];
	assign count = count_q;

endmodule
